/* sv/vspd_pkg.sv */
// Package for the voxel simple-point deletion test.
// Holds the beat types, direction codes, voxel geometry and the region-growing functions.
// No dependencies.
package vspd_pkg;

    localparam int NB_ALL      = 26;
    localparam int NB_18       = 18;
    localparam int GROW_STAGES = 5;
    localparam int GROW_STEPS  = 5;
    localparam int NUM_STAGES  = 1 + GROW_STAGES;

    // Direction codes of the thinning direction.
    typedef enum logic [2:0] {
        DIR_UP    = 3'd0,
        DIR_DOWN  = 3'd1,
        DIR_NORTH = 3'd2,
        DIR_SOUTH = 3'd3,
        DIR_EAST  = 3'd4,
        DIR_WEST  = 3'd5
    } dir_t;

    // Face bit positions within the neighbor word.
    localparam int FACE_U = 0;
    localparam int FACE_N = 1;
    localparam int FACE_W = 2;
    localparam int FACE_E = 3;
    localparam int FACE_S = 4;
    localparam int FACE_D = 5;

    typedef struct packed {
        logic [NB_ALL-1:0] neighbour_bits;
        logic [2:0]        thin_direction;
    } item_t;

    typedef struct packed {
        logic border_flag;
        logic end_flag;
        logic simple_flag;
        logic delete_flag;
    } result_t;

    // One pipeline stage: both sets, both reached regions, and the early flags.
    typedef struct packed {
        logic [NB_ALL-1:0] black_set;
        logic [NB_ALL-1:0] black_reach;
        logic [NB_ALL-1:0] white_set;
        logic [NB_ALL-1:0] white_reach;
        logic              border_flag;
        logic              end_flag;
    } stage_t;

    // Offsets of each neighbor: x W=-1 E=+1, y U=-1 D=+1, z S=-1 N=+1.
    localparam int POS_X [NB_ALL] = '{
         0, 0,-1, 1, 0, 0,
         0,-1, 1, 0,-1, 1,-1, 1, 0,-1, 1, 0,
        -1, 1,-1, 1,-1, 1,-1, 1 };
    localparam int POS_Y [NB_ALL] = '{
        -1, 0, 0, 0, 0, 1,
        -1,-1,-1,-1, 0, 0, 0, 0, 1, 1, 1, 1,
        -1,-1,-1,-1, 1, 1, 1, 1 };
    localparam int POS_Z [NB_ALL] = '{
         0, 1, 0, 0,-1, 0,
         1, 0, 0,-1, 1, 1,-1,-1, 1, 0, 0,-1,
         1, 1,-1,-1, 1, 1,-1,-1 };

    function automatic int abs_diff(input int a, input int b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Neighbors of point i: face-adjacent when six is set, else 26-adjacent.
    function automatic logic [NB_ALL-1:0] adj_mask(input int i, input logic six);
        logic [NB_ALL-1:0] m;
        int dx;
        int dy;
        int dz;
        int mx;
        m = '0;
        for (int j = 0; j < NB_ALL; j++) begin
            dx = abs_diff(POS_X[i], POS_X[j]);
            dy = abs_diff(POS_Y[i], POS_Y[j]);
            dz = abs_diff(POS_Z[i], POS_Z[j]);
            mx = (dx > dy) ? dx : dy;
            mx = (dz > mx) ? dz : mx;
            if (j != i) begin
                if (six ? ((dx + dy + dz) == 1) : (mx == 1)) begin
                    m[j] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    // One growth step of a reached region inside its set.
    function automatic logic [NB_ALL-1:0] grow_step(input logic [NB_ALL-1:0] reach,
                                                    input logic [NB_ALL-1:0] set_bits,
                                                    input logic six);
        logic [NB_ALL-1:0] g;
        g = reach;
        for (int i = 0; i < NB_ALL; i++) begin
            if (reach[i]) begin
                g = g | (adj_mask(i, six) & set_bits);
            end
        end
        return g;
    endfunction

endpackage

/* sv/voxel_simple_point_deletion_test.sv */
// Simple-point deletion test for 3-D directional thinning with 26/6 connectivity.
// Stages: entry, five growth stages of five flood steps each, and the result register.
// Throughput: one item per cycle unless result_stall fills the pipeline and raises item_stall.
// Reset: rst_n clears all valid bits asynchronously; payload registers are not reset.
// Depends on vspd_pkg.
module voxel_simple_point_deletion_test (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  vspd_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output vspd_pkg::result_t result
);
    import vspd_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    stage_t                pipe_reg  [NUM_STAGES];
    stage_t                pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] stage_ready;
    logic                  result_valid_reg;
    result_t               result_reg;
    result_t               result_next;
    logic                  out_ready;
    logic [NB_ALL-1:0]     black_bits;
    logic [NB_ALL-1:0]     white_bits;
    logic                  border_next;

    // Each stage moves when it is empty or the stage after it moves.
    always_comb
    begin
        out_ready = !result_valid_reg || !result_stall;
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign item_stall = !stage_ready[0];

    // Border test against the face neighbor of the thinning direction.
    always_comb
    begin
        case (item.thin_direction)
            DIR_UP:    border_next = !item.neighbour_bits[FACE_U];
            DIR_DOWN:  border_next = !item.neighbour_bits[FACE_D];
            DIR_NORTH: border_next = !item.neighbour_bits[FACE_N];
            DIR_SOUTH: border_next = !item.neighbour_bits[FACE_S];
            DIR_EAST:  border_next = !item.neighbour_bits[FACE_E];
            DIR_WEST:  border_next = !item.neighbour_bits[FACE_W];
            default:   border_next = 1'b0;
        endcase
    end

    // Entry stage: both sets, their lowest members as seeds, and the border and end tests.
    // Growth stages: each widens both reached regions by GROW_STEPS flood steps.
    always_comb
    begin
        black_bits = item.neighbour_bits;
        white_bits = {{(NB_ALL-NB_18){1'b0}}, ~black_bits[NB_18-1:0]};
        pipe_next[0].black_set   = black_bits;
        pipe_next[0].black_reach = black_bits & (~black_bits + 1'b1);
        pipe_next[0].white_set   = white_bits;
        pipe_next[0].white_reach = white_bits & (~white_bits + 1'b1);
        pipe_next[0].border_flag = border_next;
        pipe_next[0].end_flag    = (black_bits & (black_bits - 1'b1)) == '0;
        for (int s = 1; s < NUM_STAGES; s++) begin
            pipe_next[s] = pipe_reg[s-1];
            for (int t = 0; t < GROW_STEPS; t++) begin
                pipe_next[s].black_reach = grow_step(pipe_next[s].black_reach,
                                                     pipe_next[s].black_set, 1'b0);
                pipe_next[s].white_reach = grow_step(pipe_next[s].white_reach,
                                                     pipe_next[s].white_set, 1'b1);
            end
        end
    end

    // Final flags: a set is connected when its region reached every member.
    always_comb
    begin
        result_next.border_flag = pipe_reg[NUM_STAGES-1].border_flag;
        result_next.end_flag    = pipe_reg[NUM_STAGES-1].end_flag;
        result_next.simple_flag =
            (pipe_reg[NUM_STAGES-1].black_set != '0) &&
            (pipe_reg[NUM_STAGES-1].black_reach == pipe_reg[NUM_STAGES-1].black_set) &&
            (pipe_reg[NUM_STAGES-1].white_set != '0) &&
            (pipe_reg[NUM_STAGES-1].white_reach == pipe_reg[NUM_STAGES-1].white_set);
        result_next.delete_flag = result_next.border_flag && !result_next.end_flag &&
                                  result_next.simple_flag;
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= item_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (out_ready)
            begin
                result_valid_reg <= valid_reg[NUM_STAGES-1];
            end
        end
    end

    // Stage payloads load under the same enables.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_ready[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (out_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* tb/voxel_simple_point_deletion_test_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for voxel_simple_point_deletion_test: it predicts the
// border, end, simple and delete flags of every neighborhood beat and checks each result beat.
// Depends on vspd_pkg and the voxel_simple_point_deletion_test RTL.
module voxel_simple_point_deletion_test_tb;
    import vspd_pkg::*;

    // Direction codes outside the six faces; the block must treat them as no direction.
    localparam logic [2:0] DIR_NONE_LO = 3'd6;
    localparam logic [2:0] DIR_NONE_HI = 3'd7;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    localparam logic [NB_ALL-1:0] ALL_WHITE = '0;
    localparam logic [NB_ALL-1:0] ALL_BLACK = '1;
    localparam logic [NB_ALL-1:0] INNER18   = {{(NB_ALL-NB_18){1'b0}}, {NB_18{1'b1}}};

    localparam int SETTLE_CYCLES = 20;
    localparam int TIMEOUT_NS    = 2_000_000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Adjacency of the 26 neighbor positions, filled once at the start of the run.
    logic [NB_ALL-1:0] touch26 [NB_ALL];
    logic [NB_ALL-1:0] touch6  [NB_ALL];

    result_t pending_verdicts [$];
    result_t want;
    bit      idle_enabled = 1'b1;
    int      stall_left = 0;
    int      error_count = 0;
    int      voxels_sent = 0;
    int      verdicts_checked = 0;
    int      deletable_seen = 0;
    int      simple_seen = 0;
    int      end_seen = 0;
    int      undirected_sent = 0;

    voxel_simple_point_deletion_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #4 clk = ~clk;

    // Offset of neighbor i along one axis: x W=-1 E=+1, y U=-1 D=+1, z S=-1 N=+1.
    function automatic int coord(input int i, input int axis);
        int x;
        int y;
        int z;
        case (i)
            0:  begin x =  0; y = -1; z =  0; end
            1:  begin x =  0; y =  0; z =  1; end
            2:  begin x = -1; y =  0; z =  0; end
            3:  begin x =  1; y =  0; z =  0; end
            4:  begin x =  0; y =  0; z = -1; end
            5:  begin x =  0; y =  1; z =  0; end
            6:  begin x =  0; y = -1; z =  1; end
            7:  begin x = -1; y = -1; z =  0; end
            8:  begin x =  1; y = -1; z =  0; end
            9:  begin x =  0; y = -1; z = -1; end
            10: begin x = -1; y =  0; z =  1; end
            11: begin x =  1; y =  0; z =  1; end
            12: begin x = -1; y =  0; z = -1; end
            13: begin x =  1; y =  0; z = -1; end
            14: begin x =  0; y =  1; z =  1; end
            15: begin x = -1; y =  1; z =  0; end
            16: begin x =  1; y =  1; z =  0; end
            17: begin x =  0; y =  1; z = -1; end
            18: begin x = -1; y = -1; z =  1; end
            19: begin x =  1; y = -1; z =  1; end
            20: begin x = -1; y = -1; z = -1; end
            21: begin x =  1; y = -1; z = -1; end
            22: begin x = -1; y =  1; z =  1; end
            23: begin x =  1; y =  1; z =  1; end
            24: begin x = -1; y =  1; z = -1; end
            default: begin x = 1; y = 1; z = -1; end
        endcase
        return (axis == AXIS_X) ? x : ((axis == AXIS_Y) ? y : z);
    endfunction

    // Face bit that a thinning direction looks at, or -1 when no direction is meant.
    function automatic int face_bit(input logic [2:0] dir);
        case (dir)
            DIR_UP:    return FACE_U;
            DIR_DOWN:  return FACE_D;
            DIR_NORTH: return FACE_N;
            DIR_SOUTH: return FACE_S;
            DIR_EAST:  return FACE_E;
            DIR_WEST:  return FACE_W;
            default:   return -1;
        endcase
    endfunction

    // Flood from the lowest member; the set is one region when the flood covers it.
    function automatic bit region_connected(input logic [NB_ALL-1:0] members,
                                            input bit face_only);
        logic [NB_ALL-1:0] reached;
        logic [NB_ALL-1:0] grown;
        if (members == '0)
            return 1'b0;
        reached = members & (~members + 1'b1);
        forever
        begin
            grown = reached;
            for (int i = 0; i < NB_ALL; i++)
            begin
                if (reached[i])
                    grown |= (face_only ? touch6[i] : touch26[i]) & members;
            end
            if (grown == reached)
                break;
            reached = grown;
        end
        return reached == members;
    endfunction

    // Flags for one neighborhood beat.
    function automatic result_t judge_voxel(input item_t beat);
        result_t           verdict;
        logic [NB_ALL-1:0] black;
        logic [NB_ALL-1:0] white18;
        int                face;
        black   = beat.neighbour_bits;
        white18 = ~black & INNER18;
        face    = face_bit(beat.thin_direction);
        verdict.border_flag = (face < 0) ? 1'b0 : !black[face];
        verdict.end_flag    = ($countones(black) <= 1);
        verdict.simple_flag = region_connected(black, 1'b0) && region_connected(white18, 1'b1);
        verdict.delete_flag = verdict.border_flag && !verdict.end_flag && verdict.simple_flag;
        return verdict;
    endfunction

    // Black on one side of the voxel: the single layer, or the whole half-space when thick.
    function automatic logic [NB_ALL-1:0] plane_fill(input int axis, input int side,
                                                     input bit thick);
        logic [NB_ALL-1:0] bits;
        bits = '0;
        for (int i = 0; i < NB_ALL; i++)
            bits[i] = thick ? (coord(i, axis) * side >= 0) : (coord(i, axis) == side);
        return bits;
    endfunction

    // A 26-connected black blob grown from a random seed by random adjacent points.
    function automatic logic [NB_ALL-1:0] grow_blob(input int size);
        logic [NB_ALL-1:0] blob;
        logic [NB_ALL-1:0] frontier;
        int                pick;
        blob = '0;
        blob[$urandom_range(0, NB_ALL-1)] = 1'b1;
        for (int k = 1; k < size; k++)
        begin
            frontier = '0;
            for (int i = 0; i < NB_ALL; i++)
            begin
                if (blob[i])
                    frontier |= touch26[i];
            end
            frontier &= ~blob;
            if (frontier == '0)
                break;
            pick = $urandom_range(0, $countones(frontier) - 1);
            for (int i = 0; i < NB_ALL; i++)
            begin
                if (frontier[i])
                begin
                    if (pick == 0)
                        blob[i] = 1'b1;
                    pick--;
                end
            end
        end
        return blob;
    endfunction

    // Offer one neighborhood beat, with an optional idle burst first, and wait for acceptance.
    task automatic send_voxel(input logic [NB_ALL-1:0] bits, input logic [2:0] dir);
        item_t beat;
        beat.neighbour_bits = bits;
        beat.thin_direction = dir;
        @(negedge clk);
        if (idle_enabled && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do
            @(posedge clk);
        while (item_stall);
        pending_verdicts.insert(pending_verdicts.size(), judge_voxel(beat));
        voxels_sent++;
        if (face_bit(dir) < 0)
            undirected_sent++;
    endtask

    // Empty and full neighborhoods, one open face, the inner 18 and its complement, alternating bits.
    task automatic test_empty_and_full();
        send_voxel(ALL_WHITE, DIR_UP);
        send_voxel(ALL_BLACK, DIR_DOWN);
        send_voxel(ALL_BLACK & ~(26'd1 << FACE_U), DIR_UP);
        send_voxel(INNER18, DIR_NORTH);
        send_voxel(~INNER18, DIR_EAST);
        send_voxel(26'h2AAAAAA, DIR_SOUTH);
        send_voxel(26'h1555555, DIR_WEST);
    endtask

    // Single black neighbors are end points; pairs decide on their adjacency.
    task automatic test_end_points();
        send_voxel(26'd1 << FACE_N, DIR_SOUTH);
        send_voxel(26'd1 << (NB_ALL - 1), DIR_UP);
        send_voxel((26'd1 << FACE_U) | (26'd1 << 6), DIR_DOWN);
        send_voxel((26'd1 << FACE_U) | (26'd1 << FACE_D), DIR_NORTH);
    endtask

    // A single black layer opposite each face makes that face a deletable border.
    task automatic test_each_direction();
        int face;
        int axis;
        for (int d = DIR_UP; d <= DIR_WEST; d++)
        begin
            face = face_bit(d[2:0]);
            axis = AXIS_X;
            for (int a = AXIS_X; a <= AXIS_Z; a++)
            begin
                if (coord(face, a) != 0)
                    axis = a;
            end
            send_voxel(plane_fill(axis, -coord(face, axis), 1'b0), d[2:0]);
        end
    endtask

    // The unused direction codes never flag a border.
    task automatic test_no_direction();
        send_voxel(plane_fill(AXIS_Y, 1, 1'b1), DIR_NONE_LO);
        send_voxel(plane_fill(AXIS_Z, -1, 1'b0), DIR_NONE_HI);
        send_voxel(ALL_WHITE, DIR_NONE_HI);
    endtask

    // Mostly shaped neighborhoods (blobs, planes) with random noise and plain random words.
    task automatic test_random_voxels(input int count);
        logic [NB_ALL-1:0] bits;
        logic [2:0]        dir;
        int                pct;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1: bits = NB_ALL'($urandom);
                2, 3:
                begin
                    pct = $urandom_range(5, 95);
                    for (int i = 0; i < NB_ALL; i++)
                        bits[i] = ($urandom_range(0, 99) < pct);
                end
                4, 5, 6: bits = grow_blob($urandom_range(2, 20));
                default:
                begin
                    bits = plane_fill($urandom_range(AXIS_X, AXIS_Z),
                                      $urandom_range(0, 1) ? 1 : -1,
                                      1'($urandom_range(0, 1)));
                    repeat ($urandom_range(0, 2)) bits[$urandom_range(0, NB_ALL-1)] ^= 1'b1;
                end
            endcase
            // Half the time steer toward a white face so that deletions are common.
            dir = 3'($urandom_range(DIR_UP, DIR_WEST));
            if ($urandom_range(0, 1))
            begin
                repeat (6)
                begin
                    if (bits[face_bit(dir)])
                        dir = (dir == DIR_WEST) ? DIR_UP : dir + 1'b1;
                end
            end
            if ($urandom_range(0, 9) == 0)
                dir = 3'($urandom_range(DIR_NONE_LO, DIR_NONE_HI));
            send_voxel(bits, dir);
        end
    endtask

    // Result-side stall bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 2);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result beat with no prediction waiting: %b", result);
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (result.border_flag !== want.border_flag)
                begin
                    $error("border_flag: expected %b, got %b", want.border_flag, result.border_flag);
                    error_count++;
                end
                if (result.end_flag !== want.end_flag)
                begin
                    $error("end_flag: expected %b, got %b", want.end_flag, result.end_flag);
                    error_count++;
                end
                if (result.simple_flag !== want.simple_flag)
                begin
                    $error("simple_flag: expected %b, got %b", want.simple_flag, result.simple_flag);
                    error_count++;
                end
                if (result.delete_flag !== want.delete_flag)
                begin
                    $error("delete_flag: expected %b, got %b", want.delete_flag, result.delete_flag);
                    error_count++;
                end
                deletable_seen += want.delete_flag;
                simple_seen    += want.simple_flag;
                end_seen       += want.end_flag;
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("voxel_simple_point_deletion_test regression: fail");
        $finish;
    end

    initial
    begin
        int dx;
        int dy;
        int dz;
        // Adjacency tables from the geometry of each neighbor position.
        for (int i = 0; i < NB_ALL; i++)
        begin
            for (int j = 0; j < NB_ALL; j++)
            begin
                dx = coord(i, AXIS_X) - coord(j, AXIS_X);
                dy = coord(i, AXIS_Y) - coord(j, AXIS_Y);
                dz = coord(i, AXIS_Z) - coord(j, AXIS_Z);
                dx = (dx < 0) ? -dx : dx;
                dy = (dy < 0) ? -dy : dy;
                dz = (dz < 0) ? -dz : dz;
                touch26[i][j] = (i != j) && dx <= 1 && dy <= 1 && dz <= 1;
                touch6[i][j]  = (dx + dy + dz == 1);
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_full();
        test_end_points();
        test_each_direction();
        test_no_direction();
        test_random_voxels(900);
        idle_enabled = 1'b0;
        test_random_voxels(300);

        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d result beats for %0d voxels, %0d of them with no direction.",
                 verdicts_checked, voxels_sent, undirected_sent);
        $display("Seen: %0d deletable, %0d simple, %0d end points.",
                 deletable_seen, simple_seen, end_seen);
        if (error_count == 0)
            $display("voxel_simple_point_deletion_test regression: pass");
        else
            $display("voxel_simple_point_deletion_test regression: fail");
        $finish;
    end

endmodule

/* voxel_simple_point_deletion_test.f */
sv/vspd_pkg.sv
sv/voxel_simple_point_deletion_test.sv
tb/voxel_simple_point_deletion_test_tb.sv
